// ===== design/bwg_pkg.sv =====
// Package for the bit width gearbox: shared constants, register indexes and
// the command and status bundles between the controller and the datapath.
// No dependencies.
`default_nettype none

package bwg_pkg;

   // Largest supported word and block width (default for MAX_WIDTH)
   localparam int DEFAULT_MAX_WIDTH = 64;

   // Width registers are seven bits wide and reset to eight
   localparam int CFG_W = 7;
   localparam logic [CFG_W-1:0] RESET_WIDTH = 7'd8;

   // Register indexes on the write port
   typedef enum logic [0:0] {
      REG_IN_WIDTH  = 1'b0,
      REG_OUT_WIDTH = 1'b1
   } reg_index_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // take the accepted input word into the shift store
      logic step;   // move one chunk of bits into the accumulator
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic fill;      // the pending step completes a block
      logic done;      // the pending step uses up the input word
      logic out_free;  // the output register can take a block this cycle
   } sts_type;

endpackage

`default_nettype wire

// ===== design/bit_width_gearbox.sv =====
// Bit width gearbox. An accepted word is first loaded into the shift store,
// then takes one step per cycle, held while a completed block would overwrite
// one still waiting on rsp_tready; a step fills the open block or uses up the
// word. The first block shows once the load and the step that fills it have
// both been registered. Synchronous reset empties the accumulator, drops any
// pending beat and sets both widths to eight.
// Top level; depends on bwg_pkg, bwg_controller and bwg_datapath.
`default_nettype none

module bit_width_gearbox
   import bwg_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration writes
   input  wire logic                             csr_wen,
   input  wire logic                             csr_index,
   input  wire logic [CFG_W-1:0]                 csr_wdata,
   // input words
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [8*((MAX_WIDTH+7)/8)-1:0]   req_tdata,  // data_in
   // output blocks
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [8*((MAX_WIDTH+7)/8)-1:0]   rsp_tdata,  // block_out
   output logic                                  rsp_tlast
);

   localparam int DATA_W = 8 * ((MAX_WIDTH + 7) / 8);

   cmd_type              cmd;
   sts_type              sts;
   logic [MAX_WIDTH-1:0] block_out;

   bwg_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .cmd      (cmd),
      .sts      (sts)
   );

   bwg_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .data_in   (req_tdata[MAX_WIDTH-1:0]),
      .block_out (block_out),
      .last_out  (rsp_tlast),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Pad the block up to whole bytes
   assign rsp_tdata = DATA_W'(block_out);

endmodule

`default_nettype wire

// ===== design/bwg_datapath.sv =====
// Datapath of the bit width gearbox: width registers, input shift store,
// accumulator and output register. Depends on bwg_pkg.
`default_nettype none

module bwg_datapath
   import bwg_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration writes
   input  wire logic                 csr_wen,
   input  wire logic                 csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   // input word and output block
   input  wire logic [MAX_WIDTH-1:0] data_in,
   output logic      [MAX_WIDTH-1:0] block_out,
   output logic                      last_out,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   // controller link
   input  wire cmd_type              cmd,
   output sts_type                   sts
);

   localparam int CW = $clog2(MAX_WIDTH + 1);

   logic [CFG_W-1:0]     in_width_ff,  in_width_in;
   logic [CFG_W-1:0]     out_width_ff, out_width_in;
   logic [MAX_WIDTH-1:0] held_bits_ff, held_bits_in;
   logic [CW-1:0]        held_cnt_ff,  held_cnt_in;
   logic [MAX_WIDTH-1:0] rem_bits_ff,  rem_bits_in;
   logic [CW-1:0]        rem_cnt_ff,   rem_cnt_in;
   logic [MAX_WIDTH-1:0] out_bits_ff,  out_bits_in;
   logic                 out_last_ff,  out_last_in;
   logic                 out_valid_ff, out_valid_in;

   logic [CW-1:0]        iw, ow;
   logic [CW-1:0]        space, take, rem_left;
   logic                 fill;
   logic [MAX_WIDTH-1:0] chunk, merged;

   // Map zero to one and anything above the maximum to the maximum
   function automatic logic [CW-1:0] clamp_width(input logic [CFG_W-1:0] w);
      logic [CW-1:0] r;
      if (w == '0) begin
         r = CW'(1);
      end else if (w > CFG_W'(MAX_WIDTH)) begin
         r = CW'(MAX_WIDTH);
      end else begin
         r = CW'(w);
      end
      return r;
   endfunction

   assign iw = clamp_width(in_width_ff);
   assign ow = clamp_width(out_width_ff);

   // Size the next chunk: the room left in the block or the bits left
   always_comb begin
      space    = ow - held_cnt_ff;
      take     = (rem_cnt_ff < space) ? rem_cnt_ff : space;
      fill     = (take == space);
      rem_left = rem_cnt_ff - take;
      chunk    = rem_bits_ff & ~({MAX_WIDTH{1'b1}} << take);
      merged   = held_bits_ff | (chunk << held_cnt_ff);
   end

   assign sts.fill     = fill;
   assign sts.done     = (rem_left == '0);
   assign sts.out_free = !out_valid_ff || out_ready;

   // Next-state logic
   always_comb begin
      in_width_in  = in_width_ff;
      out_width_in = out_width_ff;
      held_bits_in = held_bits_ff;
      held_cnt_in  = held_cnt_ff;
      rem_bits_in  = rem_bits_ff;
      rem_cnt_in   = rem_cnt_ff;
      out_bits_in  = out_bits_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;

      // drop the beat once taken
      if (out_ready) begin
         out_valid_in = 1'b0;
      end

      // load a fresh word; only its low iw bits are ever consumed
      if (cmd.load) begin
         rem_bits_in = data_in;
         rem_cnt_in  = iw;
      end

      // advance one chunk; emit the block when it fills
      if (cmd.step) begin
         rem_bits_in = rem_bits_ff >> take;
         rem_cnt_in  = rem_left;
         if (fill) begin
            held_bits_in = '0;
            held_cnt_in  = '0;
            out_bits_in  = merged;
            out_last_in  = (rem_left < ow);
            out_valid_in = 1'b1;
         end else begin
            held_bits_in = merged;
            held_cnt_in  = held_cnt_ff + take;
         end
      end

      // a register write empties the accumulator
      if (csr_wen) begin
         held_bits_in = '0;
         held_cnt_in  = '0;
         case (reg_index_type'(csr_index))
            REG_IN_WIDTH:  in_width_in  = csr_wdata;
            REG_OUT_WIDTH: out_width_in = csr_wdata;
            default:       ;
         endcase
      end
   end

   // Control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= RESET_WIDTH;
         out_width_ff <= RESET_WIDTH;
         held_bits_ff <= '0;
         held_cnt_ff  <= '0;
         rem_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_width_ff  <= in_width_in;
         out_width_ff <= out_width_in;
         held_bits_ff <= held_bits_in;
         held_cnt_ff  <= held_cnt_in;
         rem_cnt_ff   <= rem_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_bits_ff <= rem_bits_in;
      out_bits_ff <= out_bits_in;
      out_last_ff <= out_last_in;
   end

   assign block_out = out_bits_ff;
   assign last_out  = out_last_ff;
   assign out_valid = out_valid_ff;

endmodule

`default_nettype wire

// ===== design/bwg_controller.sv =====
// Controller of the bit width gearbox: accepts one word at a time and steps
// the datapath until the word is used up. Depends on bwg_pkg.
`default_nettype none

module bwg_controller
   import bwg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   // Step unless a completed block would overwrite an untaken one
   always_comb begin
      cmd.load = in_valid && ready_ff;
      cmd.step = (state_ff == ST_RUN) && (!sts.fill || sts.out_free);
   end

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_RUN;
               ready_in = 1'b0;
            end
         end
         ST_RUN: begin
            if (cmd.step && sts.done) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   // Hold state and the registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign in_ready = ready_ff;

endmodule

`default_nettype wire

// ===== design/bwg_checker.sv =====
// Port-level checks for the bit width gearbox, bound to the top level.
// Depends on bit_width_gearbox.
`default_nettype none

module bwg_checker #(
   parameter int DATA_W = 64
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [DATA_W-1:0] rsp_tdata,
   input wire logic              rsp_tlast
);

   // A stalled beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // One word at a time: no new word straight after one is taken
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted twice in a row");

   // A block that is not the last of its word means the word is still in work
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("ready while a word still has blocks to give");

endmodule

bind bit_width_gearbox bwg_checker #(.DATA_W(DATA_W)) u_bwg_checker (.*);

`default_nettype wire
